### design/ocm_pkg.sv
// Shared types and constants of the order crossover multiset core.
`default_nettype none
package ocm_pkg;

   localparam int DEF_MAX_GENES = 64;
   localparam int DEF_MAX_JOBS  = 16;

   localparam int CFG_W    = 7;
   localparam int OPCODE_W = 2;
   localparam int POS_W    = 6;
   localparam int JOB_W    = 4;
   localparam int CUT_W    = 6;
   localparam int OCC_W    = 6;

   localparam logic [CFG_W-1:0] DEF_GENOME_LENGTH = 7'd64;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD_ONE = 2'd0,
      OP_LOAD_TWO = 2'd1,
      OP_RUN      = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CLEAR,
      PH_COUNT,
      PH_FILL,
      PH_EMIT
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      issue_en;
      logic      accept;
   } ctrl_cmd_type;

   typedef struct packed {
      logic advance;
      logic pipe_empty;
      logic len_zero;
   } dp_status_type;

endpackage
`default_nettype wire

### design/ocm_ctrl.sv
// Run sequencer: clear sweep, count pass, fill pass and emit pass.
`default_nettype none
module ocm_ctrl #(
   parameter int MAX_GENES = ocm_pkg::DEF_MAX_GENES,
   parameter int MAX_JOBS  = ocm_pkg::DEF_MAX_JOBS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   input  wire logic [ocm_pkg::OPCODE_W-1:0]           req_opcode,
   input  wire ocm_pkg::dp_status_type                 status,
   input  wire logic [$clog2(MAX_GENES+1)-1:0]         run_len,
   output logic                                        req_ready,
   output ocm_pkg::ctrl_cmd_type                       cmd,
   output logic [$clog2((MAX_GENES > MAX_JOBS) ? MAX_GENES : MAX_JOBS)-1:0] step_idx
);
   import ocm_pkg::*;

   localparam int LEN_W  = $clog2(MAX_GENES + 1);
   localparam int STEP_W = $clog2((MAX_GENES > MAX_JOBS) ? MAX_GENES : MAX_JOBS);
   localparam int CMP_W  = (STEP_W > LEN_W) ? STEP_W : LEN_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_COUNT,
      S_FILL,
      S_EMIT
   } state_type;

   state_type         state_ff;
   logic              req_ready_ff;
   logic              issue_en_ff;
   logic [STEP_W-1:0] step_ff;

   logic accept;
   logic run_go;
   logic step_last;
   logic clear_last;

   assign accept     = req_valid && req_ready_ff;
   assign run_go     = accept && (opcode_type'(req_opcode) == OP_RUN) && !status.len_zero;
   assign step_last  = CMP_W'(step_ff) == (CMP_W'(run_len) - CMP_W'(1));
   assign clear_last = step_ff == STEP_W'(MAX_JOBS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         issue_en_ff  <= 1'b0;
         step_ff      <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (run_go) begin
                  state_ff     <= S_CLEAR;
                  req_ready_ff <= 1'b0;
                  step_ff      <= '0;
               end
            end
            S_CLEAR: begin
               if (clear_last) begin
                  state_ff    <= S_COUNT;
                  step_ff     <= '0;
                  issue_en_ff <= 1'b1;
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            S_COUNT, S_FILL, S_EMIT: begin
               if (issue_en_ff) begin
                  if (status.advance) begin
                     if (step_last) begin
                        issue_en_ff <= 1'b0;
                        step_ff     <= '0;
                     end else begin
                        step_ff <= step_ff + STEP_W'(1);
                     end
                  end
               end else if (status.pipe_empty) begin
                  // pass drained: open the next one
                  if (state_ff == S_COUNT) begin
                     state_ff    <= S_FILL;
                     issue_en_ff <= 1'b1;
                  end else if (state_ff == S_FILL) begin
                     state_ff    <= S_EMIT;
                     issue_en_ff <= 1'b1;
                  end else begin
                     state_ff     <= S_IDLE;
                     req_ready_ff <= 1'b1;
                  end
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_ready_ff <= 1'b1;
               issue_en_ff  <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      unique case (state_ff)
         S_IDLE:  cmd.phase = PH_IDLE;
         S_CLEAR: cmd.phase = PH_CLEAR;
         S_COUNT: cmd.phase = PH_COUNT;
         S_FILL:  cmd.phase = PH_FILL;
         S_EMIT:  cmd.phase = PH_EMIT;
         default: cmd.phase = PH_IDLE;
      endcase
   end

   assign cmd.issue_en = issue_en_ff;
   assign cmd.accept   = accept;
   assign req_ready    = req_ready_ff;
   assign step_idx     = step_ff;

endmodule
`default_nettype wire

### design/ocm_dpath.sv
// Gene stores, count memories, two-stage pass pipeline and result register.
`default_nettype none
module ocm_dpath #(
   parameter int MAX_GENES = ocm_pkg::DEF_MAX_GENES,
   parameter int MAX_JOBS  = ocm_pkg::DEF_MAX_JOBS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [ocm_pkg::CFG_W-1:0]              csr_wr_data,
   input  wire logic [ocm_pkg::OPCODE_W-1:0]           req_opcode,
   input  wire logic [ocm_pkg::POS_W-1:0]              req_position,
   input  wire logic [ocm_pkg::JOB_W-1:0]              req_job_id,
   input  wire logic [ocm_pkg::CUT_W-1:0]              req_cut_first,
   input  wire logic [ocm_pkg::CUT_W-1:0]              req_cut_second,
   input  wire ocm_pkg::ctrl_cmd_type                  cmd,
   input  wire logic [$clog2((MAX_GENES > MAX_JOBS) ? MAX_GENES : MAX_JOBS)-1:0] step_idx,
   input  wire logic                                   rsp_ready,
   output ocm_pkg::dp_status_type                      status,
   output logic [$clog2(MAX_GENES+1)-1:0]              run_len,
   output logic                                        rsp_valid,
   output logic [ocm_pkg::JOB_W-1:0]                   rsp_child_job,
   output logic [ocm_pkg::OCC_W-1:0]                   rsp_operation_index,
   output logic                                        rsp_last_gene,
   output logic                                        rsp_fill_short
);
   import ocm_pkg::*;

   localparam int GENE_W = $clog2(MAX_GENES);
   localparam int JIDX_W = $clog2(MAX_JOBS);
   localparam int LEN_W  = $clog2(MAX_GENES + 1);
   localparam int NEED_W = LEN_W;
   localparam int SUM_W  = LEN_W + 1;
   localparam int PC_W   = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam int JL_W   = $clog2(MAX_JOBS + 1);
   localparam int JC_W   = (JOB_W > JL_W) ? JOB_W : JL_W;
   localparam int CC_W   = (CUT_W > LEN_W) ? CUT_W : LEN_W;

   // configuration
   logic [CFG_W-1:0] genome_length_ff;
   logic [LEN_W-1:0] len_eff;
   logic [LEN_W-1:0] len_m1;

   // memories
   logic [JOB_W-1:0]  p1_mem    [MAX_GENES];
   logic [JOB_W-1:0]  p2_mem    [MAX_GENES];
   logic [JOB_W-1:0]  child_mem [MAX_GENES];
   logic [NEED_W-1:0] need_mem  [MAX_JOBS];
   logic [NEED_W-1:0] occ_mem   [MAX_JOBS];

   // run geometry
   logic [GENE_W-1:0] lo_ff;
   logic [GENE_W-1:0] hi_ff;
   logic [GENE_W-1:0] fill_start_ff;
   logic [GENE_W-1:0] c_ff;

   // pipeline
   logic              s1_valid_ff;
   logic [GENE_W-1:0] s1_addr_ff;
   logic [JOB_W-1:0]  p1_rd_ff;
   logic [JOB_W-1:0]  p2_rd_ff;
   logic [JOB_W-1:0]  child_rd_ff;
   logic              s2_valid_ff;
   logic [GENE_W-1:0] s2_addr_ff;
   logic [JOB_W-1:0]  s2_job_ff;
   logic [NEED_W-1:0] need_rd_ff;
   logic [NEED_W-1:0] occ_rd_ff;
   logic              fwd_valid_ff;
   logic [JIDX_W-1:0] fwd_idx_ff;
   logic [NEED_W-1:0] fwd_val_ff;

   // result register
   logic              rsp_valid_ff;
   logic [JOB_W-1:0]  rsp_child_job_ff;
   logic [OCC_W-1:0]  rsp_operation_index_ff;
   logic              rsp_last_gene_ff;
   logic              rsp_fill_short_ff;

   logic              accept_load_one;
   logic              accept_load_two;
   logic              accept_run;
   logic              load_ok;
   logic [GENE_W-1:0] load_addr;
   logic [GENE_W-1:0] cut_a;
   logic [GENE_W-1:0] cut_b;
   logic [GENE_W-1:0] seg_lo;
   logic [GENE_W-1:0] seg_hi;
   logic [LEN_W-1:0]  hi_p1;
   logic [GENE_W-1:0] fill_start;
   logic [SUM_W-1:0]  fill_sum;
   logic [GENE_W-1:0] gene_addr;
   logic              advance;
   logic              issue;
   logic [JOB_W-1:0]  s1_job;
   logic [JIDX_W-1:0] s1_jidx;
   logic [JIDX_W-1:0] s2_jidx;
   logic [NEED_W-1:0] cnt_raw;
   logic [NEED_W-1:0] cnt_cur;
   logic              in_seg;
   logic              take;
   logic              cnt_we;
   logic [NEED_W-1:0] cnt_wval;
   logic              emit;
   logic              clear_we;
   logic [JIDX_W-1:0] clear_idx;
   logic              child_we;
   logic [GENE_W-1:0] child_waddr;
   logic [JOB_W-1:0]  child_wdata;
   logic [GENE_W-1:0] c_next;

   // ---------------- configuration and length ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         genome_length_ff <= DEF_GENOME_LENGTH;
      end else if (csr_wr_en) begin
         genome_length_ff <= csr_wr_data;
      end
   end

   assign len_eff = (genome_length_ff > CFG_W'(MAX_GENES)) ? LEN_W'(MAX_GENES)
                                                           : LEN_W'(genome_length_ff);
   assign len_m1  = len_eff - LEN_W'(1);
   assign run_len = len_eff;

   // ---------------- request decode ----------------
   assign load_ok   = (PC_W'(req_position) < PC_W'(MAX_GENES)) &&
                      (JC_W'(req_job_id) < JC_W'(MAX_JOBS));
   assign load_addr = req_position[GENE_W-1:0];
   assign accept_load_one = cmd.accept && (opcode_type'(req_opcode) == OP_LOAD_ONE) && load_ok;
   assign accept_load_two = cmd.accept && (opcode_type'(req_opcode) == OP_LOAD_TWO) && load_ok;
   assign accept_run      = cmd.accept && (opcode_type'(req_opcode) == OP_RUN);

   // clamp both cuts to the last gene, then order them
   assign cut_a = (CC_W'(req_cut_first) > CC_W'(len_m1)) ? GENE_W'(len_m1)
                                                         : GENE_W'(req_cut_first);
   assign cut_b = (CC_W'(req_cut_second) > CC_W'(len_m1)) ? GENE_W'(len_m1)
                                                          : GENE_W'(req_cut_second);
   assign seg_lo     = (cut_a < cut_b) ? cut_a : cut_b;
   assign seg_hi     = (cut_a < cut_b) ? cut_b : cut_a;
   assign hi_p1      = LEN_W'(seg_hi) + LEN_W'(1);
   assign fill_start = (hi_p1 == len_eff) ? '0 : GENE_W'(hi_p1);

   // ---------------- issue address ----------------
   assign fill_sum = SUM_W'(fill_start_ff) + SUM_W'(step_idx[GENE_W-1:0]);

   always_comb begin
      if (cmd.phase == PH_FILL) begin
         gene_addr = (fill_sum >= SUM_W'(len_eff)) ? GENE_W'(fill_sum - SUM_W'(len_eff))
                                                   : GENE_W'(fill_sum);
      end else begin
         gene_addr = step_idx[GENE_W-1:0];
      end
   end

   // hold the whole pipeline while a result waits on a full output
   assign emit    = s2_valid_ff && (cmd.phase == PH_EMIT);
   assign advance = !(emit && rsp_valid_ff && !rsp_ready);
   assign issue   = cmd.issue_en && advance;

   // ---------------- stage 1 ----------------
   always_comb begin
      case (cmd.phase)
         PH_COUNT: s1_job = p1_rd_ff;
         PH_FILL:  s1_job = p2_rd_ff;
         default:  s1_job = child_rd_ff;
      endcase
   end

   assign s1_jidx = JIDX_W'(s1_job);

   // ---------------- stage 2 ----------------
   assign s2_jidx = JIDX_W'(s2_job_ff);
   assign cnt_raw = (cmd.phase == PH_EMIT) ? occ_rd_ff : need_rd_ff;
   // the previous word's count write lands in the same cycle as this read
   assign cnt_cur = (fwd_valid_ff && (fwd_idx_ff == s2_jidx)) ? fwd_val_ff : cnt_raw;
   assign in_seg  = (s2_addr_ff >= lo_ff) && (s2_addr_ff <= hi_ff);
   assign take    = s2_valid_ff && (cmd.phase == PH_FILL) && (c_ff != lo_ff) &&
                    (cnt_cur != '0);
   assign cnt_we  = (s2_valid_ff && (cmd.phase == PH_COUNT) && !in_seg) || take || emit;
   assign cnt_wval = take ? (cnt_cur - NEED_W'(1)) : (cnt_cur + NEED_W'(1));
   assign c_next  = (LEN_W'(c_ff) == len_m1) ? '0 : (c_ff + GENE_W'(1));

   assign clear_we  = cmd.phase == PH_CLEAR;
   assign clear_idx = step_idx[JIDX_W-1:0];

   always_comb begin
      child_we    = 1'b0;
      child_waddr = s2_addr_ff;
      child_wdata = s2_job_ff;
      if (advance && s2_valid_ff && (cmd.phase == PH_COUNT)) begin
         // segment genes copy parent one, the rest start as job zero
         child_we    = 1'b1;
         child_wdata = in_seg ? s2_job_ff : '0;
      end else if (advance && take) begin
         child_we    = 1'b1;
         child_waddr = c_ff;
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (accept_load_one) begin
         p1_mem[load_addr] <= req_job_id;
      end
      if (accept_load_two) begin
         p2_mem[load_addr] <= req_job_id;
      end
      if (child_we) begin
         child_mem[child_waddr] <= child_wdata;
      end
      if (advance) begin
         p1_rd_ff    <= p1_mem[gene_addr];
         p2_rd_ff    <= p2_mem[gene_addr];
         child_rd_ff <= child_mem[gene_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clear_we) begin
         need_mem[clear_idx] <= '0;
      end else if (advance && cnt_we && (cmd.phase != PH_EMIT)) begin
         need_mem[s2_jidx] <= cnt_wval;
      end
      if (clear_we) begin
         occ_mem[clear_idx] <= '0;
      end else if (advance && cnt_we && (cmd.phase == PH_EMIT)) begin
         occ_mem[s2_jidx] <= cnt_wval;
      end
      if (advance) begin
         need_rd_ff <= need_mem[s1_jidx];
         occ_rd_ff  <= occ_mem[s1_jidx];
      end
   end

   // ---------------- pipeline control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         fwd_valid_ff <= cnt_we;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_addr_ff <= gene_addr;
         s2_addr_ff <= s1_addr_ff;
         s2_job_ff  <= s1_job;
         fwd_idx_ff <= s2_jidx;
         fwd_val_ff <= cnt_wval;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_run) begin
         lo_ff         <= seg_lo;
         hi_ff         <= seg_hi;
         fill_start_ff <= fill_start;
         c_ff          <= fill_start;
      end else if (advance && take) begin
         c_ff <= c_next;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_child_job_ff       <= s2_job_ff;
         rsp_operation_index_ff <= OCC_W'(cnt_cur);
         rsp_last_gene_ff       <= LEN_W'(s2_addr_ff) == len_m1;
         rsp_fill_short_ff      <= c_ff != lo_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_child_job       = rsp_child_job_ff;
   assign rsp_operation_index = rsp_operation_index_ff;
   assign rsp_last_gene       = rsp_last_gene_ff;
   assign rsp_fill_short      = rsp_fill_short_ff;

   assign status.advance    = advance;
   assign status.pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign status.len_zero   = len_eff == '0;

endmodule
`default_nettype wire

### design/order_crossover_multiset_core.sv
// Load words are accepted back to back while idle.
// A run word starts a clearing sweep over the MAX_JOBS entries of the count memories,
// then count, fill and emit passes of len reads each through a two-stage memory
// pipeline, one gene a cycle while a waiting result does not hold the emit pass.
// Reset clears control state and sets the length to 64; gene stores stay undefined.
`default_nettype none
module order_crossover_multiset_core #(
   parameter int MAX_GENES = ocm_pkg::DEF_MAX_GENES,
   parameter int MAX_JOBS  = ocm_pkg::DEF_MAX_JOBS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [ocm_pkg::CFG_W-1:0]     csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ocm_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [ocm_pkg::POS_W-1:0]     req_position,
   input  wire logic [ocm_pkg::JOB_W-1:0]     req_job_id,
   input  wire logic [ocm_pkg::CUT_W-1:0]     req_cut_first,
   input  wire logic [ocm_pkg::CUT_W-1:0]     req_cut_second,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ocm_pkg::JOB_W-1:0]          rsp_child_job,
   output logic [ocm_pkg::OCC_W-1:0]          rsp_operation_index,
   output logic                               rsp_last_gene,
   output logic                               rsp_fill_short
);
   import ocm_pkg::*;

   localparam int LEN_W  = $clog2(MAX_GENES + 1);
   localparam int STEP_W = $clog2((MAX_GENES > MAX_JOBS) ? MAX_GENES : MAX_JOBS);

   ctrl_cmd_type      cmd;
   dp_status_type     status;
   logic [LEN_W-1:0]  run_len;
   logic [STEP_W-1:0] step_idx;

   ocm_ctrl #(
      .MAX_GENES (MAX_GENES),
      .MAX_JOBS  (MAX_JOBS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .status     (status),
      .run_len    (run_len),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .step_idx   (step_idx)
   );

   ocm_dpath #(
      .MAX_GENES (MAX_GENES),
      .MAX_JOBS  (MAX_JOBS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_opcode          (req_opcode),
      .req_position        (req_position),
      .req_job_id          (req_job_id),
      .req_cut_first       (req_cut_first),
      .req_cut_second      (req_cut_second),
      .cmd                 (cmd),
      .step_idx            (step_idx),
      .rsp_ready           (rsp_ready),
      .status              (status),
      .run_len             (run_len),
      .rsp_valid           (rsp_valid),
      .rsp_child_job       (rsp_child_job),
      .rsp_operation_index (rsp_operation_index),
      .rsp_last_gene       (rsp_last_gene),
      .rsp_fill_short      (rsp_fill_short)
   );

   // only the emit pass may hold the pipeline
   a_stall_in_emit : assert property (@(posedge clock) disable iff (reset)
      !status.advance |-> (cmd.phase == PH_EMIT))
      else $error("pipeline held outside the emit pass");

   // no gene is issued while new words are taken
   a_no_issue_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.issue_en |-> !req_ready)
      else $error("gene issued while accepting words");

   // the pass pipeline is drained whenever the core is ready
   a_idle_drained : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (status.pipe_empty && (cmd.phase == PH_IDLE)))
      else $error("ready with words still in the pipeline");

endmodule
`default_nettype wire
